@@ hdl/pfa_pkg.sv @@
`timescale 1ns / 1ps
// Package for the partition fit allocator: field widths, codes and payload types.
// No dependencies.
package pfa_pkg;
  localparam int unsigned MaxEntries = 16;
  localparam int unsigned AddrBits   = 16;
  localparam int unsigned OwnerBits  = 8;
  localparam int unsigned SlotBits   = $clog2(MaxEntries);
  localparam int unsigned CountBits  = SlotBits + 1;

  typedef enum logic [2:0] {
    ACT_APPEND   = 3'd0,
    ACT_ALLOC    = 3'd1,
    ACT_FREE_ALL = 3'd2,
    ACT_COALESCE = 3'd3,
    ACT_READ     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_FIT    = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef struct packed {
    logic [2:0]          action;
    logic [AddrBits-1:0] part_begin;
    logic [AddrBits-1:0] part_finish;
    logic [AddrBits-1:0] request_size;
    logic [OwnerBits-1:0] owner_tag;
    logic [SlotBits-1:0] read_slot;
  } cmd_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [SlotBits-1:0]  slot;
    logic [AddrBits-1:0]  slot_begin;
    logic [AddrBits-1:0]  slot_finish;
    logic                 slot_used;
    logic [OwnerBits-1:0] slot_owner;
    logic [CountBits-1:0] entry_count;
  } rsp_t;

  // One stored table entry; the used flag lives in flip-flops beside the memory.
  typedef struct packed {
    logic [AddrBits-1:0]  base;
    logic [AddrBits-1:0]  limit;
    logic [OwnerBits-1:0] owner;
  } entry_t;
endpackage

@@ hdl/pfa_table_ram.sv @@
`timescale 1ns / 1ps
// Partition table storage: one write port, one read port, registered read data.
// Depends on nothing outside this file.
module pfa_table_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ hdl/partition_fit_allocator_unit.sv @@
`timescale 1ns / 1ps
// Partition fit allocator top level: command sequencer around the table memory.
// Depends on pfa_pkg and pfa_table_ram.
// Append, free all, unknown action, bad read, empty or short table: done from idle; read:
//   one registered memory read; allocate: one read per entry, then on a split the entries
//   above the pick move up and the hole and front are written; coalesce: one read per entry.
// Throughput: one command at a time; busy stays high until done_o pulses.
// Reset clears the count, all used flags and the policy (first fit); the receiver cannot stall.
module partition_fit_allocator_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  pfa_pkg::cmd_t cmd_i,
  output logic          done_o,
  output pfa_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_data_i
);
  import pfa_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASCAN = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_HOLE  = 4'd3;
  localparam logic [3:0] S_FRONT = 4'd4;
  localparam logic [3:0] S_RDW   = 4'd5;
  localparam logic [3:0] S_COAL  = 4'd6;

  logic [3:0]           state_q, state_d;
  cmd_t                 cmd_q, cmd_d;
  logic [1:0]           policy_q;
  logic [CountBits-1:0] count_q, count_d;
  logic [MaxEntries-1:0] used_q, used_d;
  // Scan pointer and the read pipeline tag (which entry the read data belongs to)
  logic [CountBits-1:0] scan_q, scan_d;
  logic                 pv_q, pv_d;
  logic [SlotBits-1:0]  paddr_q, paddr_d;
  // Allocation pick
  logic                 found_q, found_d;
  logic [SlotBits-1:0]  pick_q, pick_d;
  logic [AddrBits-1:0]  plen_q, plen_d, pbeg_q, pbeg_d, pfin_q, pfin_d;
  // Coalesce accumulator and write pointer
  entry_t               cur_q, cur_d;
  logic                 cur_u_q, cur_u_d, cur_v_q, cur_v_d;
  logic [SlotBits-1:0]  w_q, w_d;
  // Result register
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;

  // Memory port
  logic                 we, re;
  logic [SlotBits-1:0]  waddr, raddr;
  entry_t               wdata, rdata;
  logic [$bits(entry_t)-1:0] rdata_raw;

  pfa_table_ram #(
    .Depth(MaxEntries),
    .Width($bits(entry_t))
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  logic                e_used, e_fit, take;
  logic [AddrBits-1:0] e_len, split_end;
  logic [CountBits-1:0] pick_ext;

  always_comb begin
    state_d  = state_q;
    cmd_d    = cmd_q;
    count_d  = count_q;
    used_d   = used_q;
    scan_d   = scan_q;
    pv_d     = 1'b0;
    paddr_d  = paddr_q;
    found_d  = found_q;
    pick_d   = pick_q;
    plen_d   = plen_q;
    pbeg_d   = pbeg_q;
    pfin_d   = pfin_q;
    cur_d    = cur_q;
    cur_u_d  = cur_u_q;
    cur_v_d  = cur_v_q;
    w_d      = w_q;
    done_d   = 1'b0;
    rsp_d    = rsp_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    re       = 1'b0;
    raddr    = '0;

    e_used    = used_q[paddr_q];
    e_len     = rdata.limit - rdata.base;
    e_fit     = !e_used && (rdata.limit >= rdata.base) && (e_len >= cmd_q.request_size);
    take      = e_fit && (!found_q || (policy_q == POL_BEST && e_len < plen_q) ||
                (policy_q == POL_WORST && e_len > plen_q));
    split_end = pbeg_q + cmd_q.request_size;
    pick_ext  = {1'b0, pick_q};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_d   = cmd_i;
          scan_d  = '0;
          found_d = 1'b0;
          cur_v_d = 1'b0;
          w_d     = '0;
          rsp_d   = '0;
          unique case (cmd_i.action)
            ACT_APPEND: begin
              done_d = 1'b1;
              if (count_q >= CountBits'(MaxEntries)) begin
                rsp_d.status      = ST_FULL;
                rsp_d.entry_count = count_q;
              end else begin
                we    = 1'b1;
                waddr = count_q[SlotBits-1:0];
                wdata = '{base: cmd_i.part_begin, limit: cmd_i.part_finish, owner: '0};
                used_d[count_q[SlotBits-1:0]] = 1'b0;
                count_d           = count_q + 1'b1;
                rsp_d.slot        = count_q[SlotBits-1:0];
                rsp_d.slot_begin  = cmd_i.part_begin;
                rsp_d.slot_finish = cmd_i.part_finish;
                rsp_d.entry_count = count_q + 1'b1;
              end
            end
            ACT_ALLOC: begin
              if (count_q == '0) begin
                done_d            = 1'b1;
                rsp_d.status      = ST_EMPTY;
                rsp_d.entry_count = count_q;
              end else begin
                state_d = S_ASCAN;
              end
            end
            ACT_FREE_ALL: begin
              used_d            = '0;
              done_d            = 1'b1;
              rsp_d.entry_count = count_q;
            end
            ACT_COALESCE: begin
              if (count_q < CountBits'(2)) begin
                done_d            = 1'b1;
                rsp_d.entry_count = count_q;
              end else begin
                state_d = S_COAL;
              end
            end
            ACT_READ: begin
              if ({1'b0, cmd_i.read_slot} >= count_q) begin
                done_d            = 1'b1;
                rsp_d.status      = ST_BAD_INDEX;
                rsp_d.entry_count = count_q;
              end else begin
                re      = 1'b1;
                raddr   = cmd_i.read_slot;
                state_d = S_RDW;
              end
            end
            default: begin
              done_d            = 1'b1;
              rsp_d.entry_count = count_q;
            end
          endcase
        end
      end

      S_RDW: begin
        done_d            = 1'b1;
        rsp_d.slot        = cmd_q.read_slot;
        rsp_d.slot_begin  = rdata.base;
        rsp_d.slot_finish = rdata.limit;
        rsp_d.slot_used   = used_q[cmd_q.read_slot];
        rsp_d.slot_owner  = rdata.owner;
        rsp_d.entry_count = count_q;
        state_d           = S_IDLE;
      end

      S_ASCAN: begin
        // Issue one read per cycle, judge the entry read the cycle before
        if (scan_q < count_q) begin
          re      = 1'b1;
          raddr   = scan_q[SlotBits-1:0];
          paddr_d = scan_q[SlotBits-1:0];
          pv_d    = 1'b1;
          scan_d  = scan_q + 1'b1;
        end
        if (pv_q && take) begin
          found_d = 1'b1;
          pick_d  = paddr_q;
          plen_d  = e_len;
          pbeg_d  = rdata.base;
          pfin_d  = rdata.limit;
        end
        if (!pv_q && scan_q == count_q) begin
          rsp_d.entry_count = count_q;
          if (!found_q) begin
            rsp_d.status = ST_NO_FIT;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else if (plen_q == cmd_q.request_size) begin
            we    = 1'b1;
            waddr = pick_q;
            wdata = '{base: pbeg_q, limit: pfin_q, owner: cmd_q.owner_tag};
            used_d[pick_q]    = 1'b1;
            rsp_d.slot        = pick_q;
            rsp_d.slot_begin  = pbeg_q;
            rsp_d.slot_finish = pfin_q;
            rsp_d.slot_used   = 1'b1;
            rsp_d.slot_owner  = cmd_q.owner_tag;
            done_d            = 1'b1;
            state_d           = S_IDLE;
          end else if (count_q >= CountBits'(MaxEntries)) begin
            rsp_d.status = ST_FULL;
            done_d       = 1'b1;
            state_d      = S_IDLE;
          end else begin
            scan_d  = count_q - 1'b1;
            state_d = S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // Move entries above the pick up by one, top first
        if (scan_q > pick_ext && scan_q != '1) begin
          re      = 1'b1;
          raddr   = scan_q[SlotBits-1:0];
          paddr_d = scan_q[SlotBits-1:0];
          pv_d    = 1'b1;
          scan_d  = scan_q - 1'b1;
        end
        if (pv_q) begin
          we    = 1'b1;
          waddr = paddr_q + 1'b1;
          wdata = rdata;
          used_d[paddr_q + 1'b1] = used_q[paddr_q];
        end
        if (!pv_q && !(scan_q > pick_ext && scan_q != '1)) begin
          state_d = S_HOLE;
        end
      end

      S_HOLE: begin
        we    = 1'b1;
        waddr = pick_q + 1'b1;
        wdata = '{base: split_end, limit: pfin_q, owner: '0};
        used_d[pick_q + 1'b1] = 1'b0;
        count_d = count_q + 1'b1;
        state_d = S_FRONT;
      end

      S_FRONT: begin
        we    = 1'b1;
        waddr = pick_q;
        wdata = '{base: pbeg_q, limit: split_end, owner: cmd_q.owner_tag};
        used_d[pick_q]    = 1'b1;
        rsp_d.slot        = pick_q;
        rsp_d.slot_begin  = pbeg_q;
        rsp_d.slot_finish = split_end;
        rsp_d.slot_used   = 1'b1;
        rsp_d.slot_owner  = cmd_q.owner_tag;
        rsp_d.entry_count = count_q;
        done_d            = 1'b1;
        state_d           = S_IDLE;
      end

      S_COAL: begin
        // Stream entries through the accumulator, compacting behind the read pointer
        if (scan_q < count_q) begin
          re      = 1'b1;
          raddr   = scan_q[SlotBits-1:0];
          paddr_d = scan_q[SlotBits-1:0];
          pv_d    = 1'b1;
          scan_d  = scan_q + 1'b1;
        end
        if (pv_q) begin
          if (!cur_v_q) begin
            cur_d   = rdata;
            cur_u_d = e_used;
            cur_v_d = 1'b1;
          end else if (!cur_u_q && !e_used) begin
            cur_d.limit = cur_q.limit + rdata.limit - rdata.base;
          end else begin
            we      = 1'b1;
            waddr   = w_q;
            wdata   = cur_q;
            used_d[w_q] = cur_u_q;
            w_d     = w_q + 1'b1;
            cur_d   = rdata;
            cur_u_d = e_used;
          end
        end
        if (!pv_q && scan_q == count_q) begin
          we      = 1'b1;
          waddr   = w_q;
          wdata   = cur_q;
          used_d[w_q] = cur_u_q;
          count_d = {1'b0, w_q} + 1'b1;
          rsp_d.entry_count = {1'b0, w_q} + 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      used_q   <= '0;
      policy_q <= POL_FIRST;
      pv_q     <= 1'b0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      cur_v_q  <= 1'b0;
      scan_q   <= '0;
      w_q      <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      used_q  <= used_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
      found_q <= found_d;
      cur_v_q <= cur_v_d;
      scan_q  <= scan_d;
      w_q     <= w_d;
      if (cfg_valid_i) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    paddr_q <= paddr_d;
    pick_q  <= pick_d;
    plen_q  <= plen_d;
    pbeg_q  <= pbeg_d;
    pfin_q  <= pfin_d;
    cur_q   <= cur_d;
    cur_u_q <= cur_u_d;
    rsp_q   <= rsp_d;
  end
endmodule

@@ sim/pfa_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the partition fit allocator: keeps a shadow partition table, predicts
// each response and compares it with done_o traffic. Depends on pfa_pkg.
module pfa_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  pfa_pkg::cmd_t cmd_i,
  input  logic          done_o,
  input  pfa_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o,
  input  logic [1:0]    cfg_data_i,
  output int            fail_count,
  output int            pending
);
  import pfa_pkg::*;

  logic [AddrBits-1:0]  shadow_begin  [MaxEntries];
  logic [AddrBits-1:0]  shadow_finish [MaxEntries];
  logic                 shadow_used   [MaxEntries];
  logic [OwnerBits-1:0] shadow_owner  [MaxEntries];
  int                   shadow_count;
  logic [1:0]           policy;
  rsp_t                 expected_rsps[$];

  function automatic void shift_entry(int dst, int src);
    shadow_begin[dst]  = shadow_begin[src];
    shadow_finish[dst] = shadow_finish[src];
    shadow_used[dst]   = shadow_used[src];
    shadow_owner[dst]  = shadow_owner[src];
  endfunction

  function automatic rsp_t entry_rsp(int i);
    rsp_t r;
    r = '0;
    r.status      = ST_OK;
    r.slot        = i[SlotBits-1:0];
    r.slot_begin  = shadow_begin[i];
    r.slot_finish = shadow_finish[i];
    r.slot_used   = shadow_used[i];
    r.slot_owner  = shadow_owner[i];
    return r;
  endfunction

  // Apply one command to the shadow table and return the response it should produce.
  function automatic rsp_t predict_response(cmd_t c);
    rsp_t                r;
    logic                found;
    logic                stop;
    int                  pick;
    logic [AddrBits-1:0] pick_len;
    logic [AddrBits-1:0] len;
    int                  i;
    r = '0;
    r.status = ST_OK;
    case (c.action)
      ACT_APPEND: begin
        if (shadow_count >= MaxEntries) begin
          r.status = ST_FULL;
        end else begin
          i = shadow_count;
          shadow_count++;
          shadow_begin[i]  = c.part_begin;
          shadow_finish[i] = c.part_finish;
          shadow_used[i]   = 1'b0;
          shadow_owner[i]  = '0;
          r = entry_rsp(i);
        end
      end
      ACT_ALLOC: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          found = 1'b0;
          stop = 1'b0;
          pick = 0;
          pick_len = '0;
          for (i = 0; i < shadow_count; i++) begin
            if (!stop && !shadow_used[i] && shadow_finish[i] >= shadow_begin[i]) begin
              len = shadow_finish[i] - shadow_begin[i];
              if (len >= c.request_size &&
                  (!found || (policy == POL_BEST && len < pick_len) ||
                   (policy == POL_WORST && len > pick_len))) begin
                found = 1'b1;
                pick = i;
                pick_len = len;
                // first fit, and the unused policy code, stop at the first hit
                if (policy != POL_BEST && policy != POL_WORST) stop = 1'b1;
              end
            end
          end
          if (!found) begin
            r.status = ST_NO_FIT;
          end else if (pick_len == c.request_size) begin
            shadow_used[pick]  = 1'b1;
            shadow_owner[pick] = c.owner_tag;
            r = entry_rsp(pick);
          end else if (shadow_count >= MaxEntries) begin
            r.status = ST_FULL;
          end else begin
            for (i = shadow_count; i > pick + 1; i--) shift_entry(i, i - 1);
            shadow_count++;
            shadow_begin[pick+1]  = shadow_begin[pick] + c.request_size;
            shadow_finish[pick+1] = shadow_finish[pick];
            shadow_used[pick+1]   = 1'b0;
            shadow_owner[pick+1]  = '0;
            shadow_finish[pick]   = shadow_begin[pick] + c.request_size;
            shadow_used[pick]     = 1'b1;
            shadow_owner[pick]    = c.owner_tag;
            r = entry_rsp(pick);
          end
        end
      end
      ACT_FREE_ALL: begin
        for (i = 0; i < MaxEntries; i++) shadow_used[i] = 1'b0;
      end
      ACT_COALESCE: begin
        i = 0;
        while (i + 1 < shadow_count) begin
          if (!shadow_used[i] && !shadow_used[i+1]) begin
            shadow_finish[i] = shadow_finish[i] + shadow_finish[i+1] - shadow_begin[i+1];
            for (int j = i + 1; j + 1 < shadow_count; j++) shift_entry(j, j + 1);
            shadow_count--;
          end else begin
            i++;
          end
        end
      end
      ACT_READ: begin
        if (c.read_slot >= shadow_count) r.status = ST_BAD_INDEX;
        else r = entry_rsp(int'(c.read_slot));
      end
      default: ;
    endcase
    r.entry_count = shadow_count[CountBits-1:0];
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      for (int i = 0; i < MaxEntries; i++) shadow_used[i] = 1'b0;
      shadow_count = 0;
      policy = POL_FIRST;
      expected_rsps.delete();
      fail_count = 0;
      pending = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) policy = cfg_data_i;
      if (done_o) begin
        if (expected_rsps.size() == 0) begin
          $error("response with nothing outstanding");
          fail_count++;
        end else begin
          e = expected_rsps.pop_front();
          check_field("status", e.status, rsp_o.status);
          check_field("slot", e.slot, rsp_o.slot);
          check_field("slot_begin", e.slot_begin, rsp_o.slot_begin);
          check_field("slot_finish", e.slot_finish, rsp_o.slot_finish);
          check_field("slot_used", e.slot_used, rsp_o.slot_used);
          check_field("slot_owner", e.slot_owner, rsp_o.slot_owner);
          check_field("entry_count", e.entry_count, rsp_o.entry_count);
        end
      end
      if (start && !busy) expected_rsps.push_back(predict_response(cmd_i));
      pending = expected_rsps.size();
    end
  end
endmodule

@@ sim/partition_fit_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, command and policy stimulus, verdict.
// Depends on pfa_pkg, partition_fit_allocator_unit and pfa_checker.
module partition_fit_allocator_unit_test;
  import pfa_pkg::*;

  localparam int CycleLimit = 400000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  cmd_t          cmd_i = '0;
  logic          done_o;
  rsp_t          rsp_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [1:0]    cfg_data_i = '0;
  int            fail_count;
  int            pending;
  int            cycle_count = 0;
  int            idle_pct = 0;
  logic [AddrBits-1:0] next_base = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  partition_fit_allocator_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  pfa_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .cmd_i(cmd_i),
    .done_o(done_o), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .fail_count(fail_count), .pending(pending)
  );

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Present one command and hold it until the transfer; start stays high afterwards
  // unless an idle gap is drawn, so back-to-back commands never toggle it twice.
  task automatic send_cmd(cmd_t c);
    int gap;
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(action_e a, int pb, int pf, int sz, int own, int rs);
    cmd_t c;
    c = '0;
    c.action       = a;
    c.part_begin   = AddrBits'(pb);
    c.part_finish  = AddrBits'(pf);
    c.request_size = AddrBits'(sz);
    c.owner_tag    = OwnerBits'(own);
    c.read_slot    = SlotBits'(rs);
    send_cmd(c);
  endtask

  // Drain all outstanding responses, then leave room for any tail of work.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_policy(logic [1:0] p);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: contiguous appends, small allocations, reads,
  // with occasional release/merge and a slice of fully random noise.
  function automatic cmd_t random_cmd();
    cmd_t        c;
    int          pick;
    int          len;
    logic [63:0] raw;
    c = '0;
    c.owner_tag = OwnerBits'($urandom_range(255));
    c.read_slot = SlotBits'($urandom_range(15));
    c.part_begin = AddrBits'($urandom);
    c.part_finish = AddrBits'($urandom);
    c.request_size = AddrBits'($urandom_range(0, 320));
    pick = $urandom_range(99);
    if (pick < 10) begin
      raw = {$urandom, $urandom};
      c = raw[$bits(cmd_t)-1:0];
    end else if (pick < 35) begin
      c.action = ACT_APPEND;
      len = $urandom_range(0, 300);
      if ($urandom_range(19) != 0) begin
        c.part_begin  = next_base;
        c.part_finish = next_base + AddrBits'(len);
        next_base = next_base + AddrBits'(len);
      end
    end else if (pick < 70) begin
      c.action = ACT_ALLOC;
      if ($urandom_range(9) == 0) c.request_size = AddrBits'($urandom);
    end else if (pick < 77) begin
      c.action = ACT_FREE_ALL;
    end else if (pick < 85) begin
      c.action = ACT_COALESCE;
    end else begin
      c.action = ACT_READ;
    end
    return c;
  endfunction

  initial begin
    int idle_set[4];
    idle_set = '{0, 71, 0, 31};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, every action, each corner under first fit.
    write_policy(POL_FIRST);
    send_fields(ACT_READ, 0, 0, 0, 0, 0);              // read on empty table
    send_fields(ACT_ALLOC, 0, 0, 0, 8'h5a, 0);         // allocate on empty table
    send_fields(ACT_APPEND, 16'hffff, 0, 0, 0, 0);     // reversed entry
    send_fields(ACT_APPEND, 0, 16'hffff, 0, 0, 0);     // full address range
    send_fields(ACT_APPEND, 100, 100, 0, 0, 0);        // zero length
    send_fields(ACT_ALLOC, 0, 0, 16'hffff, 8'hff, 0);  // exact match of full range
    send_fields(ACT_ALLOC, 0, 0, 0, 8'h01, 0);         // zero request
    send_fields(ACT_ALLOC, 0, 0, 1, 8'h02, 0);         // no fit
    send_fields(ACT_READ, 0, 0, 0, 0, 15);             // bad index
    send_fields(ACT_FREE_ALL, 0, 0, 0, 0, 0);
    send_fields(ACT_ALLOC, 0, 0, 16'h1000, 8'h80, 0);  // split, new hole
    send_fields(ACT_READ, 0, 0, 0, 0, 2);
    send_fields(action_e'(3'd5), 0, 0, 0, 0, 0);
    send_fields(action_e'(3'd7), 16'hffff, 16'hffff, 16'hffff, 8'hff, 15);
    for (int i = 0; i < 13; i++) send_fields(ACT_APPEND, i * 10, i * 10 + 9, 0, 0, 0);
    send_fields(ACT_APPEND, 1, 2, 0, 0, 0);            // append with full table
    send_fields(ACT_ALLOC, 0, 0, 3, 8'h33, 0);         // split with full table
    send_fields(ACT_READ, 0, 0, 0, 0, 15);
    send_fields(ACT_FREE_ALL, 0, 0, 0, 0, 0);
    send_fields(ACT_COALESCE, 0, 0, 0, 0, 0);          // fold everything, address wrap
    send_fields(ACT_READ, 0, 0, 0, 0, 0);

    // Random phases cycling through policies and sender idle rates.
    for (int ph = 0; ph < 9; ph++) begin
      write_policy(ph == 8 ? 2'd3 : 2'(ph % 3));
      idle_pct = idle_set[ph % 4];
      for (int n = 0; n < 55; n++) begin
        send_cmd(random_cmd());
        if (n == 30) wait_drained();                  // hold until all responses are in
      end
    end

    wait_drained();
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
